// ----- design/wrdp_pkg.sv -----
// Shared types and fixed-point constants for the wall ray distance predictor.
package wrdp_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int QBITS          = ANGLE_BITS - 2;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int POS_FRAC_BITS  = 7;

    localparam int TRIG_W  = 17;
    localparam int POS_W   = 18;
    localparam int FIELD_W = 15;
    localparam int DIST_W  = 16;

    // Polynomial coefficients of the quarter-wave sine, Q20.
    localparam logic [16:0] PC = 17'd74235;
    localparam logic [19:0] PB = 20'd672758;
    localparam logic [20:0] PA = 21'd1647099;

    localparam logic [ANGLE_BITS-1:0] QTURN       = ANGLE_BITS'(1 << QBITS);
    localparam logic [FIELD_W-1:0]    FIELD_RESET = 15'd18432;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [POS_W-1:0]  pos_t;

    typedef struct packed {
        pos_t  sx;
        pos_t  sy;
        trig_t vx;
        trig_t vy;
    } ray_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

// ----- design/wall_ray_distance_predictor.sv -----
// Top level of the wall ray distance predictor.
// Fully pipelined: when nothing stalls, one transaction is accepted per cycle and
// results leave at the same rate. A transaction passes the front pipeline
// (five-stage polynomial sine lanes, then the offset rotation), the queue, and
// the back pipeline (wall tests, nearest-hit selection, a 16-stage restoring
// divider and the output register). The input stalls only while the queue
// between the two halves is full, which happens when the result side backs up.
// field_size may be written only while no transaction is in flight.
module wall_ray_distance_predictor import wrdp_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FIELD_W-1:0] cfg_field_size,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_robot_x,
    input  logic signed [15:0] s_robot_y,
    input  logic [15:0]        s_heading,
    input  logic signed [12:0] s_sensor_forward,
    input  logic signed [12:0] s_sensor_right,
    input  logic [15:0]        s_sensor_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DIST_W-1:0]  m_distance,
    output logic               m_valid_res
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic [FIELD_W-1:0] field_size_reg;
    q_stat_t            q_stat;
    logic               q_push, q_pop;
    ray_t               q_din, q_dout;
    logic [CNT_W-1:0]   q_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_size_reg <= FIELD_RESET;
        end else if (cfg_valid) begin
            field_size_reg <= cfg_field_size;
        end
    end

    wrdp_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_robot_x        (s_robot_x),
        .s_robot_y        (s_robot_y),
        .s_heading        (s_heading),
        .s_sensor_forward (s_sensor_forward),
        .s_sensor_right   (s_sensor_right),
        .s_sensor_angle   (s_sensor_angle),
        .q_stat           (q_stat),
        .push             (q_push),
        .ray              (q_din)
    );

    wrdp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .dout    (q_dout),
        .stat    (q_stat),
        .count   (q_count)
    );

    wrdp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .field_size  (field_size_reg),
        .q_stat      (q_stat),
        .head        (q_dout),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_distance  (m_distance),
        .m_valid_res (m_valid_res)
    );

    // A hit always has a nonzero distance, and a miss reports zero.
    a_hit_distance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_valid_res == (m_distance != '0)))
        else $error("hit flag and distance disagree");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !q_push)
        else $error("push into a full queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- design/wrdp_sine.sv -----
// Five-stage pipelined polynomial sine of a binary angle.
module wrdp_sine import wrdp_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output trig_t                 sin_out
);

    logic [1:0]  quad1_reg, quad2_reg, quad3_reg, quad4_reg;
    logic [20:0] x1_reg, x2_reg, x3_reg, x4_reg;
    logic [20:0] sq2_reg, sq3_reg;
    logic [17:0] t1_reg;
    logic [20:0] t2_reg;
    trig_t       sin_reg;

    logic [QBITS:0]  r_fold;
    logic [41:0]     sq_prod;
    logic [37:0]     t1_prod;
    logic [19:0]     pb_diff;
    logic [40:0]     t2_prod;
    logic [20:0]     pa_diff;
    logic [41:0]     t3_prod;
    logic [22:0]     rnd_sum;
    logic [TRIG_W-1:0] mag;

    always_comb begin
        // Mirror the angle within odd quadrants.
        if (angle[QBITS]) begin
            r_fold = (QBITS+1)'(1 << QBITS) - {1'b0, angle[QBITS-1:0]};
        end else begin
            r_fold = {1'b0, angle[QBITS-1:0]};
        end
        sq_prod = x1_reg * x1_reg;
        t1_prod = PC * sq2_reg;
        pb_diff = PB - {2'b0, t1_reg};
        t2_prod = sq3_reg * pb_diff;
        pa_diff = PA - t2_reg;
        t3_prod = x4_reg * pa_diff;
        rnd_sum = {1'b0, t3_prod[41:20]} + 23'd16;
        mag     = rnd_sum[21:5];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad1_reg <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
            x1_reg    <= 21'({r_fold, 6'b0});
            quad2_reg <= quad1_reg;
            x2_reg    <= x1_reg;
            sq2_reg   <= sq_prod[40:20];
            quad3_reg <= quad2_reg;
            x3_reg    <= x2_reg;
            sq3_reg   <= sq2_reg;
            t1_reg    <= t1_prod[37:20];
            quad4_reg <= quad3_reg;
            x4_reg    <= x3_reg;
            t2_reg    <= t2_prod[40:20];
            if (quad4_reg[1]) begin
                sin_reg <= -$signed(mag);
            end else begin
                sin_reg <= $signed(mag);
            end
        end
    end

    assign sin_out = sin_reg;

endmodule

// ----- design/wrdp_front.sv -----
// Front pipeline: accepts poses, computes trig values and the sensor position.
module wrdp_front import wrdp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [15:0]    s_robot_x,
    input  logic signed [15:0]    s_robot_y,
    input  logic [15:0]           s_heading,
    input  logic signed [12:0]    s_sensor_forward,
    input  logic signed [12:0]    s_sensor_right,
    input  logic [15:0]           s_sensor_angle,
    input  q_stat_t               q_stat,
    output logic                  push,
    output ray_t                  ray
);

    localparam int SIN_LAT = 5;
    localparam int NSTG    = SIN_LAT + 2;

    logic adv, accept;
    logic [NSTG-1:0] vld_reg;

    logic signed [15:0] rx_reg  [SIN_LAT];
    logic signed [15:0] ry_reg  [SIN_LAT];
    logic signed [12:0] fwd_reg [SIN_LAT];
    logic signed [12:0] rgt_reg [SIN_LAT];

    logic [ANGLE_BITS-1:0] th, thq, g, gq;
    trig_t st, ct, vx, vy;

    logic signed [29:0] p_fs_reg, p_rc_reg, p_fc_reg, p_rs_reg;
    logic signed [15:0] rx6_reg, ry6_reg;
    trig_t vx6_reg, vy6_reg;
    ray_t  ray_reg;

    logic signed [30:0] sx_sum, sy_sum;

    assign adv     = !q_stat.full;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    assign th  = s_heading;
    assign thq = s_heading + QTURN;
    assign g   = s_heading + s_sensor_angle;
    assign gq  = g + QTURN;

    wrdp_sine u_sin_t (.aclk(aclk), .en(adv), .angle(th),  .sin_out(st));
    wrdp_sine u_cos_t (.aclk(aclk), .en(adv), .angle(thq), .sin_out(ct));
    wrdp_sine u_sin_g (.aclk(aclk), .en(adv), .angle(g),   .sin_out(vx));
    wrdp_sine u_cos_g (.aclk(aclk), .en(adv), .angle(gq),  .sin_out(vy));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], accept};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rx_reg[0]  <= s_robot_x;
            ry_reg[0]  <= s_robot_y;
            fwd_reg[0] <= s_sensor_forward;
            rgt_reg[0] <= s_sensor_right;
            for (int i = 1; i < SIN_LAT; i++) begin
                rx_reg[i]  <= rx_reg[i-1];
                ry_reg[i]  <= ry_reg[i-1];
                fwd_reg[i] <= fwd_reg[i-1];
                rgt_reg[i] <= rgt_reg[i-1];
            end
        end
    end

    always_comb begin
        // Rounding half toward +infinity is an add and an arithmetic shift.
        sx_sum = 31'(p_fs_reg) + 31'(p_rc_reg) + 31'sd16384;
        sy_sum = 31'(p_fc_reg) - 31'(p_rs_reg) + 31'sd16384;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_fs_reg <= fwd_reg[SIN_LAT-1] * st;
            p_rc_reg <= rgt_reg[SIN_LAT-1] * ct;
            p_fc_reg <= fwd_reg[SIN_LAT-1] * ct;
            p_rs_reg <= rgt_reg[SIN_LAT-1] * st;
            rx6_reg  <= rx_reg[SIN_LAT-1];
            ry6_reg  <= ry_reg[SIN_LAT-1];
            vx6_reg  <= vx;
            vy6_reg  <= vy;
            ray_reg.sx <= POS_W'(rx6_reg) + POS_W'(sx_sum >>> TRIG_FRAC_BITS);
            ray_reg.sy <= POS_W'(ry6_reg) + POS_W'(sy_sum >>> TRIG_FRAC_BITS);
            ray_reg.vx <= vx6_reg;
            ray_reg.vy <= vy6_reg;
        end
    end

    assign push = vld_reg[NSTG-1] && adv;
    assign ray  = ray_reg;

endmodule

// ----- design/wrdp_queue.sv -----
// Short register queue between the front and back pipelines.
module wrdp_queue import wrdp_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  ray_t                       din,
    input  logic                       pop,
    output ray_t                       dout,
    output q_stat_t                    stat,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    ray_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout       = mem_reg[rd_ptr_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign count      = cnt_reg;

endmodule

// ----- design/wrdp_back.sv -----
// Back pipeline: wall hit tests, nearest-hit selection and distance division.
module wrdp_back import wrdp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [FIELD_W-1:0] field_size,
    input  q_stat_t            q_stat,
    input  ray_t               head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DIST_W-1:0]  m_distance,
    output logic               m_valid_res
);

    localparam int SEL_STG = 7;
    localparam int NSTG    = SEL_STG + DIST_W;
    localparam int REM_W   = 35;

    logic adv;
    logic [NSTG-1:0] vld_reg;
    logic m_valid_reg, m_valid_res_reg;
    logic [DIST_W-1:0] m_distance_reg;

    // Wall test, first stage.
    logic signed [18:0] f_s, hsx, hsy;
    logic signed [18:0] d_c [4];
    logic signed [18:0] d_reg [4];
    trig_t              va_reg [4];
    logic signed [34:0] ovx_reg, ovy_reg;
    logic signed [35:0] dv_reg [4];
    logic [30:0]        fvax_reg, fvay_reg;
    logic [15:0]        avx, avy;
    trig_t              vax_abs, vay_abs;

    // Wall test, second stage.
    logic signed [39:0] p_c [4];
    logic signed [39:0] pn_c [4];
    logic signed [18:0] dabs_c [4];
    trig_t              vabs_c [4];
    logic               hit_c [4];
    logic               hit_reg [4];
    logic [18:0]        num_reg [4];
    logic [15:0]        den_reg [4];

    // Pair compare.
    logic [34:0] lhs3_reg [2], rhs3_reg [2];
    logic        h3_reg [4];
    logic [18:0] n3_reg [4];
    logic [15:0] e3_reg [4];
    logic        h4_reg [2];
    logic [18:0] n4_reg [2];
    logic [15:0] e4_reg [2];
    logic [34:0] lhs5_reg, rhs5_reg;
    logic        h5_reg [2];
    logic [18:0] n5_reg [2];
    logic [15:0] e5_reg [2];
    logic        have6_reg;
    logic [18:0] n6_reg;
    logic [15:0] e6_reg;

    // Division.
    logic [REM_W-1:0]  rem_reg  [DIST_W+1];
    logic [DIST_W-1:0] q_reg    [DIST_W+1];
    logic [15:0]       dd_reg   [DIST_W+1];
    logic              sat_reg  [DIST_W+1];
    logic              have_reg [DIST_W+1];
    logic [REM_W-1:0]  n_next;

    assign adv = !m_valid_reg || m_ready;
    assign pop = adv && !q_stat.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[NSTG-2:0], !q_stat.empty};
            m_valid_reg <= vld_reg[NSTG-1];
        end
    end

    always_comb begin
        f_s     = $signed({4'b0, field_size});
        hsx     = 19'(head.sx);
        hsy     = 19'(head.sy);
        d_c[0]  = -hsx;
        d_c[1]  = f_s - hsx;
        d_c[2]  = -hsy;
        d_c[3]  = f_s - hsy;
        vax_abs = head.vx[TRIG_W-1] ? -head.vx : head.vx;
        vay_abs = head.vy[TRIG_W-1] ? -head.vy : head.vy;
        avx     = vax_abs[15:0];
        avy     = vay_abs[15:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int w = 0; w < 4; w++) begin
                d_reg[w]  <= d_c[w];
                va_reg[w] <= (w < 2) ? head.vx : head.vy;
                dv_reg[w] <= d_c[w] * ((w < 2) ? head.vy : head.vx);
            end
            ovx_reg  <= head.sy * head.vx;
            ovy_reg  <= head.sx * head.vy;
            fvax_reg <= field_size * avx;
            fvay_reg <= field_size * avy;
        end
    end

    always_comb begin
        for (int w = 0; w < 4; w++) begin
            p_c[w]    = ((w < 2) ? 40'(ovx_reg) : 40'(ovy_reg)) + 40'(dv_reg[w]);
            pn_c[w]   = va_reg[w][TRIG_W-1] ? -p_c[w] : p_c[w];
            dabs_c[w] = d_reg[w][18] ? -d_reg[w] : d_reg[w];
            vabs_c[w] = va_reg[w][TRIG_W-1] ? -va_reg[w] : va_reg[w];
            // A hit must lie ahead of the sensor and land within the wall span.
            hit_c[w]  = (va_reg[w] != '0) && (d_reg[w] != '0)
                        && (d_reg[w][18] == va_reg[w][TRIG_W-1])
                        && !pn_c[w][39]
                        && (pn_c[w] <= $signed({9'b0, (w < 2) ? fvax_reg : fvay_reg}));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int w = 0; w < 4; w++) begin
                hit_reg[w] <= hit_c[w];
                num_reg[w] <= dabs_c[w];
                den_reg[w] <= vabs_c[w][15:0];
            end
        end
    end

    // Walls are compared in list order; the earlier one wins a tie.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 2; k++) begin
                lhs3_reg[k] <= num_reg[2*k+1] * den_reg[2*k];
                rhs3_reg[k] <= num_reg[2*k] * den_reg[2*k+1];
            end
            for (int w = 0; w < 4; w++) begin
                h3_reg[w] <= hit_reg[w];
                n3_reg[w] <= num_reg[w];
                e3_reg[w] <= den_reg[w];
            end
            for (int k = 0; k < 2; k++) begin
                h4_reg[k] <= h3_reg[2*k] || h3_reg[2*k+1];
                if (h3_reg[2*k+1] && (!h3_reg[2*k] || (lhs3_reg[k] < rhs3_reg[k]))) begin
                    n4_reg[k] <= n3_reg[2*k+1];
                    e4_reg[k] <= e3_reg[2*k+1];
                end else begin
                    n4_reg[k] <= n3_reg[2*k];
                    e4_reg[k] <= e3_reg[2*k];
                end
            end
            lhs5_reg <= n4_reg[1] * e4_reg[0];
            rhs5_reg <= n4_reg[0] * e4_reg[1];
            for (int k = 0; k < 2; k++) begin
                h5_reg[k] <= h4_reg[k];
                n5_reg[k] <= n4_reg[k];
                e5_reg[k] <= e4_reg[k];
            end
            have6_reg <= h5_reg[0] || h5_reg[1];
            if (h5_reg[1] && (!h5_reg[0] || (lhs5_reg < rhs5_reg))) begin
                n6_reg <= n5_reg[1];
                e6_reg <= e5_reg[1];
            end else begin
                n6_reg <= n5_reg[0];
                e6_reg <= e5_reg[0];
            end
        end
    end

    assign n_next = {1'b0, n6_reg, 15'b0} + REM_W'(e6_reg >> 1);

    // Restoring division, one quotient bit per stage, most significant first.
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= n_next;
            q_reg[0]    <= '0;
            dd_reg[0]   <= e6_reg;
            sat_reg[0]  <= n_next >= REM_W'({e6_reg, 16'b0});
            have_reg[0] <= have6_reg;
            for (int j = 0; j < DIST_W; j++) begin
                dd_reg[j+1]   <= dd_reg[j];
                sat_reg[j+1]  <= sat_reg[j];
                have_reg[j+1] <= have_reg[j];
                if (rem_reg[j] >= (REM_W'(dd_reg[j]) << (DIST_W-1-j))) begin
                    rem_reg[j+1] <= rem_reg[j] - (REM_W'(dd_reg[j]) << (DIST_W-1-j));
                    q_reg[j+1]   <= q_reg[j] | (DIST_W'(1) << (DIST_W-1-j));
                end else begin
                    rem_reg[j+1] <= rem_reg[j];
                    q_reg[j+1]   <= q_reg[j];
                end
            end
            m_valid_res_reg <= have_reg[DIST_W];
            if (!have_reg[DIST_W]) begin
                m_distance_reg <= '0;
            end else if (sat_reg[DIST_W]) begin
                m_distance_reg <= '1;
            end else begin
                m_distance_reg <= q_reg[DIST_W];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_distance  = m_distance_reg;
    assign m_valid_res = m_valid_res_reg;

endmodule

// ----- tb/tb_wall_ray_distance_predictor.sv -----
// Self-checking testbench for the wall ray distance predictor: random and directed poses.
module tb_wall_ray_distance_predictor;
    import wrdp_pkg::*;

    typedef struct {
        logic [15:0] distance;
        logic        hit;
    } range_t;

    class range_board;
        range_t pending[$];
        int     errors;
        logic [FIELD_W-1:0] field;

        function longint sine_quarter(longint r);
            longint x, x2, t;
            x  = r << (20 - QBITS);
            x2 = (x * x) >>> 20;
            t  = (longint'(PC) * x2) >>> 20;
            t  = (x2 * (longint'(PB) - t)) >>> 20;
            t  = (x * (longint'(PA) - t)) >>> 20;
            return (t + 16) >>> 5;
        endfunction

        function longint sine(longint a);
            longint q, r, v;
            q = (a >> QBITS) & 3;
            r = a & ((1 << QBITS) - 1);
            if (q & 1)
                r = (1 << QBITS) - r;
            v = sine_quarter(r);
            return (q & 2) ? -v : v;
        endfunction

        // Rounds half toward positive infinity.
        function longint round_up_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function void wall(longint d, longint va, longint o, longint vo, longint f,
                           inout bit have, inout longint bn, inout longint bd);
            longint p;
            if (va == 0 || d == 0)
                return;
            if ((d > 0) != (va > 0))
                return;
            p = o * va + d * vo;
            if (va < 0) begin
                p = -p;
                va = -va;
                d = -d;
            end
            if (p < 0 || p > f * va)
                return;
            if (!have || d * bd < bn * va) begin
                have = 1;
                bn = d;
                bd = va;
            end
        endfunction

        function void note_pose(logic signed [15:0] rx, logic signed [15:0] ry,
                                logic [15:0] th, logic signed [12:0] fw,
                                logic signed [12:0] rt, logic [15:0] sa);
            longint st, ct, vx, vy, sx, sy, f, bn, bd, d;
            logic [15:0] g;
            bit have;
            range_t e;
            g  = th + sa;
            st = sine(th);
            ct = sine(16'(th + QTURN));
            vx = sine(g);
            vy = sine(16'(g + QTURN));
            sx = rx + round_up_shift(fw * st + rt * ct, TRIG_FRAC_BITS);
            sy = ry + round_up_shift(fw * ct - rt * st, TRIG_FRAC_BITS);
            f  = field;
            have = 0;
            bn = 0;
            bd = 1;
            wall(-sx, vx, sy, vy, f, have, bn, bd);
            wall(f - sx, vx, sy, vy, f, have, bn, bd);
            wall(-sy, vy, sx, vx, f, have, bn, bd);
            wall(f - sy, vy, sx, vx, f, have, bn, bd);
            if (have) begin
                d = ((bn << TRIG_FRAC_BITS) + (bd >> 1)) / bd;
                e.distance = d > 65535 ? 16'hFFFF : 16'(d);
                e.hit = 1;
            end else begin
                e.distance = 0;
                e.hit = 0;
            end
            pending.push_back(e);
        endfunction

        function void check_range(logic [15:0] got_distance, logic hit);
            range_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result distance=%0d hit=%0b", $time,
                         got_distance, hit);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got_distance !== e.distance) begin
                $display("%0t: distance expected %0d actual %0d", $time, e.distance,
                         got_distance);
                errors++;
            end
            if (hit !== e.hit) begin
                $display("%0t: valid_res expected %0b actual %0b", $time, e.hit, hit);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [FIELD_W-1:0] cfg_field_size = '0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [15:0] s_robot_x = 0, s_robot_y = 0;
    logic [15:0] s_heading = 0, s_sensor_angle = 0;
    logic signed [12:0] s_sensor_forward = 0, s_sensor_right = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [DIST_W-1:0] m_distance;
    logic m_valid_res;

    range_board board;
    int send_idle = 0, recv_idle = 0;
    int hold_off = 0;
    longint cycles = 0;

    wall_ray_distance_predictor i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_field_size(cfg_field_size),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_robot_x(s_robot_x), .s_robot_y(s_robot_y), .s_heading(s_heading),
        .s_sensor_forward(s_sensor_forward), .s_sensor_right(s_sensor_right),
        .s_sensor_angle(s_sensor_angle),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_distance(m_distance), .m_valid_res(m_valid_res)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_valid && m_ready)
            board.check_range(m_distance, m_valid_res);

    // Receiver: random stalls, plus long hold-offs counted here.
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_ready <= 0;
        end else begin
            m_ready <= $urandom_range(99) >= recv_idle;
        end
    end

    task automatic write_field(logic [FIELD_W-1:0] v);
        cfg_field_size <= v;
        cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        board.field = v;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic send_pose(logic [15:0] rx, logic [15:0] ry, logic [15:0] th,
                             logic [12:0] fw, logic [12:0] rt, logic [15:0] sa);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_robot_x <= rx;
        s_robot_y <= ry;
        s_heading <= th;
        s_sensor_forward <= fw;
        s_sensor_right <= rt;
        s_sensor_angle <= sa;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.note_pose(rx, ry, th, fw, rt, sa);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // Mostly poses inside the field with modest offsets; some anywhere.
    task automatic random_pose;
        int f;
        f = board.field;
        if ($urandom_range(9) < 8)
            send_pose(16'($urandom_range(f)), 16'($urandom_range(f)), 16'($urandom),
                      13'($signed($urandom_range(1600)) - 800),
                      13'($signed($urandom_range(1600)) - 800), 16'($urandom));
        else
            send_pose(16'($urandom), 16'($urandom), 16'($urandom),
                      13'($urandom), 13'($urandom), 16'($urandom));
    endtask

    initial begin
        logic [FIELD_W-1:0] sizes[6];
        board = new();
        board.field = FIELD_RESET;
        sizes = '{15'd1, 15'd32767, 15'd18432, 15'd5000, 15'd0, 15'd300};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: compass headings, wall lines, corners, field extremes.
        send_idle = 0;
        recv_idle = 0;
        send_pose(16'd9216, 16'd9216, 16'h0000, 13'd0, 13'd0, 16'h0000);
        send_pose(16'd9216, 16'd9216, 16'h4000, 13'd0, 13'd0, 16'h0000);
        send_pose(16'd9216, 16'd9216, 16'h8000, 13'd0, 13'd0, 16'h0000);
        send_pose(16'd9216, 16'd9216, 16'hC000, 13'd0, 13'd0, 16'h0000);
        send_pose(16'd9216, 16'd9216, 16'hF000, 13'd0, 13'd0, 16'h3000);
        send_pose(16'd0, 16'd9216, 16'hC000, 13'd0, 13'd0, 16'h0000);
        send_pose(16'd0, 16'd0, 16'h2000, 13'd0, 13'd0, 16'h0000);
        send_pose(16'd0, 16'd0, 16'hA000, 13'd0, 13'd0, 16'h0000);
        send_pose(16'h8000, 16'h8000, 16'h2000, 13'h1000, 13'h1000, 16'hFFFF);
        send_pose(16'h7FFF, 16'h7FFF, 16'hFFFF, 13'h0FFF, 13'h0FFF, 16'hFFFF);
        send_pose(16'h7FFF, 16'h0000, 16'hC000, 13'h1000, 13'h0FFF, 16'h0001);
        send_pose(16'd100, 16'd100, 16'h4000, 13'h1000, 13'h1000, 16'h8000);
        send_pose(16'd9216, 16'd9216, 16'h1234, 13'd640, -13'sd640, 16'h4321);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_field(sizes[ph]);
            if (ph == 0 || ph == 3) begin
                send_idle = 26;
                recv_idle = 55;
            end else if (ph == 1 || ph == 4) begin
                send_idle = 55;
                recv_idle = 26;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (ph == 2)
                hold_off = 200;
            send_pose(16'(sizes[ph]), 16'(sizes[ph]), 16'h6000, 13'd0, 13'd0, 16'h0000);
            for (int i = 0; i < 75; i++)
                random_pose();
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
